// ----- hw/rtl/h264rtp_pkg.sv -----
package h264rtp_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int BEAT_IDX_BITS = 4;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;

  typedef enum logic [1:0] {
    REG_SOURCE_ID       = 2'd0,
    REG_PT_CODE         = 2'd1,
    REG_MAX_PACKET_SIZE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    JOB_SINGLE = 2'd0,
    JOB_FRAG   = 2'd1,
    JOB_DATA   = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [31:0] source_id;
    logic [6:0]  pt_code;
    logic [11:0] max_packet_size;
  } cfg_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic        pkt_end;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
  } job_t;

endpackage

// ----- hw/rtl/h264rtp_front.sv -----
module h264rtp_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  h264rtp_pkg::cfg_t      cfg,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  input  logic [LENGTH_BITS-1:0] unit_length,
  input  logic [31:0]            timestamp,
  input  logic                   marker_request,
  output logic                   job_push,
  output h264rtp_pkg::job_t      job
);
  import h264rtp_pkg::*;

  localparam int PB = 11;
  localparam int CW = (LENGTH_BITS > PB) ? LENGTH_BITS : PB;
  localparam logic [11:0] SIZE_DEFAULT = 12'd512;
  localparam logic [11:0] SIZE_MIN = 12'd16;
  localparam logic [11:0] SIZE_MAX = 12'd2048;
  localparam logic [4:0] FU_A_TYPE = 5'd28;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_AUD = 5'd9;

  logic [15:0]            sequence_number;
  logic [LENGTH_BITS-1:0] unit_bytes_left;
  logic [PB-1:0]          packet_bytes_left;
  logic                   fragmented_mode;
  logic [7:0]             fu_indicator_value;
  logic [4:0]             fu_type_bits;
  logic                   first_fragment_flag;
  logic                   marker_latch;
  logic [31:0]            timestamp_latch;

  logic [15:0]            sequence_number_next;
  logic [LENGTH_BITS-1:0] unit_bytes_left_next;
  logic [PB-1:0]          packet_bytes_left_next;
  logic                   fragmented_mode_next;
  logic [7:0]             fu_indicator_value_next;
  logic [4:0]             fu_type_bits_next;
  logic                   first_fragment_flag_next;
  logic                   marker_latch_next;
  logic [31:0]            timestamp_latch_next;

  logic [11:0]            size_fixed;
  logic [PB-1:0]          payload;
  logic [PB-1:0]          frag_size;
  logic [LENGTH_BITS-1:0] len_eff;
  logic [4:0]             unit_kind;
  logic                   marker_new;
  logic                   last_frag;
  logic [PB-1:0]          pbl_frag;

  always_comb begin
    priority if (cfg.max_packet_size == 12'd0) begin
      size_fixed = SIZE_DEFAULT;
    end else if (cfg.max_packet_size < SIZE_MIN) begin
      size_fixed = SIZE_MIN;
    end else if (cfg.max_packet_size > SIZE_MAX) begin
      size_fixed = SIZE_MAX;
    end else begin
      size_fixed = cfg.max_packet_size;
    end
  end

  assign payload = PB'(size_fixed - 12'(HEADER_BYTES));
  assign frag_size = payload - PB'(2);
  assign len_eff = (unit_length == '0) ? LENGTH_BITS'(1) : unit_length;
  assign unit_kind = data_byte[4:0];
  assign marker_new = marker_request || unit_kind == NAL_SPS || unit_kind == NAL_PPS
                      || unit_kind == NAL_AUD;
  assign last_frag = CW'(unit_bytes_left) <= CW'(frag_size);
  assign pbl_frag = last_frag ? PB'(unit_bytes_left) : frag_size;

  always_comb begin
    sequence_number_next     = sequence_number;
    unit_bytes_left_next     = unit_bytes_left;
    packet_bytes_left_next   = packet_bytes_left;
    fragmented_mode_next     = fragmented_mode;
    fu_indicator_value_next  = fu_indicator_value;
    fu_type_bits_next        = fu_type_bits;
    first_fragment_flag_next = first_fragment_flag;
    marker_latch_next        = marker_latch;
    timestamp_latch_next     = timestamp_latch;
    job_push                 = 1'b0;
    job.kind                 = JOB_DATA;
    job.data                 = data_byte;
    job.pkt_end              = 1'b0;
    job.marker               = 1'b0;
    job.seq                  = sequence_number;
    job.ts                   = timestamp_latch;
    job.fu_ind               = fu_indicator_value;
    job.fu_hdr               = 8'd0;
    if (first_byte) begin
      timestamp_latch_next = timestamp;
      marker_latch_next    = marker_new;
      unit_bytes_left_next = len_eff - LENGTH_BITS'(1);
      job.ts               = timestamp;
      if (CW'(len_eff) <= CW'(payload)) begin
        fragmented_mode_next   = 1'b0;
        packet_bytes_left_next = PB'(len_eff - LENGTH_BITS'(1));
        sequence_number_next   = sequence_number + 16'd1;
        job_push               = accept;
        job.kind               = JOB_SINGLE;
        job.marker             = marker_new;
        job.pkt_end            = (len_eff == LENGTH_BITS'(1));
      end else begin
        fragmented_mode_next     = 1'b1;
        packet_bytes_left_next   = '0;
        fu_indicator_value_next  = {1'b0, data_byte[6:5], FU_A_TYPE};
        fu_type_bits_next        = unit_kind;
        first_fragment_flag_next = 1'b1;
      end
    end else if (unit_bytes_left != '0) begin
      unit_bytes_left_next = unit_bytes_left - LENGTH_BITS'(1);
      if (packet_bytes_left == '0) begin
        if (fragmented_mode) begin
          packet_bytes_left_next   = pbl_frag - PB'(1);
          first_fragment_flag_next = 1'b0;
          sequence_number_next     = sequence_number + 16'd1;
          job_push                 = accept;
          job.kind                 = JOB_FRAG;
          job.marker               = last_frag && marker_latch;
          job.fu_hdr               = {first_fragment_flag, last_frag, 1'b0, fu_type_bits};
          job.pkt_end              = (pbl_frag == PB'(1));
        end else begin
          unit_bytes_left_next = unit_bytes_left;
        end
      end else begin
        packet_bytes_left_next = packet_bytes_left - PB'(1);
        job_push               = accept;
        job.kind               = JOB_DATA;
        job.pkt_end            = (packet_bytes_left == PB'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_number     <= '0;
      unit_bytes_left     <= '0;
      packet_bytes_left   <= '0;
      fragmented_mode     <= 1'b0;
      fu_indicator_value  <= '0;
      fu_type_bits        <= '0;
      first_fragment_flag <= 1'b0;
      marker_latch        <= 1'b0;
      timestamp_latch     <= '0;
    end else if (accept) begin
      sequence_number     <= sequence_number_next;
      unit_bytes_left     <= unit_bytes_left_next;
      packet_bytes_left   <= packet_bytes_left_next;
      fragmented_mode     <= fragmented_mode_next;
      fu_indicator_value  <= fu_indicator_value_next;
      fu_type_bits        <= fu_type_bits_next;
      first_fragment_flag <= first_fragment_flag_next;
      marker_latch        <= marker_latch_next;
      timestamp_latch     <= timestamp_latch_next;
    end
  end

endmodule

// ----- hw/rtl/h264rtp_queue.sv -----
module h264rtp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  h264rtp_pkg::job_t wr_job,
  input  logic              rd_en,
  output h264rtp_pkg::job_t rd_job,
  output logic              not_empty,
  output logic              is_full
);
  import h264rtp_pkg::*;

  job_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign rd_job = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign is_full = (count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (QUEUE_PTR_BITS + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (QUEUE_PTR_BITS + 1)'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/h264rtp_back.sv -----
module h264rtp_back (
  input  logic              clk,
  input  logic              rst,
  input  h264rtp_pkg::cfg_t cfg,
  input  logic              job_valid,
  input  h264rtp_pkg::job_t job,
  output logic              job_pop,
  input  logic              pop,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              packet_start,
  output logic              packet_end,
  output logic              run_last
);
  import h264rtp_pkg::*;

  localparam logic [BEAT_IDX_BITS-1:0] IDX_FU_IND = BEAT_IDX_BITS'(HEADER_BYTES);
  localparam logic [BEAT_IDX_BITS-1:0] IDX_FU_HDR = BEAT_IDX_BITS'(HEADER_BYTES + 1);
  localparam logic [BEAT_IDX_BITS-1:0] IDX_FRAG_DATA = BEAT_IDX_BITS'(HEADER_BYTES + 2);

  logic [BEAT_IDX_BITS-1:0] idx;
  logic [BEAT_IDX_BITS-1:0] last_idx;
  logic                     beat;
  logic                     at_data;
  logic [7:0]               byte_next;

  always_comb begin
    unique case (job.kind)
      JOB_SINGLE: last_idx = IDX_FU_IND;
      JOB_FRAG:   last_idx = IDX_FRAG_DATA;
      JOB_DATA:   last_idx = '0;
      default:    last_idx = '0;
    endcase
  end

  assign beat = job_valid && (!out_valid || pop);
  assign at_data = (idx == last_idx);
  assign job_pop = beat && at_data;

  always_comb begin
    if (at_data) begin
      byte_next = job.data;
    end else begin
      unique case (idx)
        4'd0:       byte_next = RTP_VERSION_BYTE;
        4'd1:       byte_next = {job.marker, cfg.pt_code};
        4'd2:       byte_next = job.seq[15:8];
        4'd3:       byte_next = job.seq[7:0];
        4'd4:       byte_next = job.ts[31:24];
        4'd5:       byte_next = job.ts[23:16];
        4'd6:       byte_next = job.ts[15:8];
        4'd7:       byte_next = job.ts[7:0];
        4'd8:       byte_next = cfg.source_id[31:24];
        4'd9:       byte_next = cfg.source_id[23:16];
        4'd10:      byte_next = cfg.source_id[15:8];
        4'd11:      byte_next = cfg.source_id[7:0];
        IDX_FU_IND: byte_next = job.fu_ind;
        IDX_FU_HDR: byte_next = job.fu_hdr;
        default:    byte_next = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (beat) begin
      out_valid <= 1'b1;
      idx       <= at_data ? '0 : idx + BEAT_IDX_BITS'(1);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      out_byte     <= byte_next;
      packet_start <= !at_data && idx == '0;
      packet_end   <= at_data && job.pkt_end;
      run_last     <= at_data;
    end
  end

endmodule

// ----- hw/rtl/h264_rtp_packetizer.sv -----
// A byte's first result beat is registered in the job queue, then in the output register.
// Throughput: one input byte per cycle while payload streams and the queue is not full; a byte
// opening a packet takes 13 output beats (15 for a fragment), one a cycle unless pop stalls.
// The four-entry job queue lets input keep flowing while headers are serialized.
// Reset empties the queue, clears out_valid and all unit state; registers return to defaults.
module h264_rtp_packetizer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             data_byte,
  input  logic                   first_byte,
  input  logic [LENGTH_BITS-1:0] unit_length,
  input  logic [31:0]            timestamp,
  input  logic                   marker_request,
  output logic                   empty,
  input  logic                   pop,
  output logic [7:0]             out_byte,
  output logic                   packet_start,
  output logic                   packet_end,
  output logic                   run_last
);
  import h264rtp_pkg::*;

  cfg_t cfg;
  job_t front_job;
  job_t head_job;
  logic job_push;
  logic job_pop;
  logic queue_valid;
  logic queue_full;
  logic out_valid;
  logic accept;

  assign cfg_ready = !rst;
  assign full = queue_full || rst;
  assign empty = !out_valid || rst;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_id       <= 32'd0;
      cfg.pt_code         <= 7'd96;
      cfg.max_packet_size <= 12'd512;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_ID:       cfg.source_id <= cfg_data;
        REG_PT_CODE:         cfg.pt_code <= cfg_data[6:0];
        REG_MAX_PACKET_SIZE: cfg.max_packet_size <= cfg_data[11:0];
        default:             cfg <= cfg;
      endcase
    end
  end

  h264rtp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .data_byte      (data_byte),
    .first_byte     (first_byte),
    .unit_length    (unit_length),
    .timestamp      (timestamp),
    .marker_request (marker_request),
    .job_push       (job_push),
    .job            (front_job)
  );

  h264rtp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_job    (front_job),
    .rd_en     (job_pop),
    .rd_job    (head_job),
    .not_empty (queue_valid),
    .is_full   (queue_full)
  );

  h264rtp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (queue_valid),
    .job          (head_job),
    .job_pop      (job_pop),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .packet_start (packet_start),
    .packet_end   (packet_end),
    .run_last     (run_last)
  );

endmodule

// ----- hw/rtl/h264rtp_checker.sv -----
module h264rtp_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       packet_start,
  input logic       packet_end,
  input logic       run_last
);
  import h264rtp_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("Result queue not empty after reset.");

  a_start_is_version: assert property (@(posedge clk) disable iff (rst)
    (!empty && packet_start) |-> (out_byte == RTP_VERSION_BYTE && !packet_end && !run_last))
    else $error("Packet start beat is not a version byte.");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && packet_end) |-> run_last)
    else $error("Packet end beat does not close its run.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)))
    else $error("Stalled result beat changed.");

endmodule

bind h264_rtp_packetizer h264rtp_checker u_checker (.*);
